>>> design/whrf_pkg.sv
// whrf_pkg: types, constants and small helper functions for the window height range filter
// stands alone; used by whrf_cell and window_height_range_filter_top
`default_nettype none

package whrf_pkg;

   localparam int MAX_COLS   = 512;
   localparam int MAX_ROWS   = 1024;
   localparam int MAX_RADIUS = 7;
   localparam int WIN_ROWS   = 2 * MAX_RADIUS + 1;
   localparam int MIN_VALID  = 2;

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int SLOT_W = $clog2(WIN_ROWS);
   localparam int RAD_W  = 3;
   localparam int ROWS_W = ROW_W + 1;
   localparam int COLS_W = COL_W + 1;
   localparam int CNT_W  = 2;

   // register indexes
   localparam logic [1:0] CSR_GRID_ROWS     = 2'd0;
   localparam logic [1:0] CSR_GRID_COLS     = 2'd1;
   localparam logic [1:0] CSR_WINDOW_RADIUS = 2'd2;

   typedef struct packed {
      logic signed [15:0] height;
      logic               height_valid;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic [15:0]      height_range;
      logic             range_valid;
      logic             batch_last;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic signed [15:0] height;
   } entry_type;

   // running window summary: min, max and a count saturating at two
   typedef struct packed {
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      logic [CNT_W-1:0]   cnt;
   } part_type;

   localparam part_type PART_EMPTY = '{lo: 16'sh7fff, hi: -16'sh8000, cnt: '0};

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [COL_W-1:0] col;
      part_type         part;
   } token_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      entry_type        entry;
   } wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_FEED,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b);
      logic [SLOT_W:0] t;
      t = {1'b0, a} - {1'b0, b};
      if (t[SLOT_W]) t = t + (SLOT_W+1)'(WIN_ROWS);
      return t[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] a);
      logic [SLOT_W-1:0] r;
      if (a == SLOT_W'(WIN_ROWS - 1)) r = '0;
      else r = a + SLOT_W'(1);
      return r;
   endfunction

   function automatic part_type merge_part(input part_type a, input part_type b);
      part_type r;
      r.lo  = (b.lo < a.lo) ? b.lo : a.lo;
      r.hi  = (b.hi > a.hi) ? b.hi : a.hi;
      r.cnt = ({1'b0, a.cnt} + {1'b0, b.cnt} >= (CNT_W+1)'(MIN_VALID)) ?
              CNT_W'(MIN_VALID) : CNT_W'(a.cnt + b.cnt);
      return r;
   endfunction

   function automatic part_type add_entry(input part_type a, input entry_type e);
      part_type r;
      r = a;
      if (e.valid) begin
         r.lo  = (e.height < a.lo) ? e.height : a.lo;
         r.hi  = (e.height > a.hi) ? e.height : a.hi;
         r.cnt = (a.cnt == CNT_W'(MIN_VALID)) ? a.cnt : a.cnt + CNT_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/whrf_cell.sv
// whrf_cell: one window row slot; holds one line of the store and folds its entry into
// the passing column item. depends on whrf_pkg
`default_nettype none

module whrf_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire whrf_pkg::wr_type  wr,
   input  wire logic              use_row,
   input  wire whrf_pkg::token_type tok_in,
   output whrf_pkg::token_type    tok_out
);

   whrf_pkg::entry_type mem [whrf_pkg::MAX_COLS];
   whrf_pkg::entry_type rd_ff;
   whrf_pkg::token_type stage_ff;
   whrf_pkg::token_type out_ff;
   whrf_pkg::token_type out_in;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr.col] <= wr.entry;
      rd_ff <= mem[tok_in.col];
   end

   always_comb begin
      out_in = stage_ff;
      if (use_row) out_in.part = whrf_pkg::add_entry(stage_ff.part, rd_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
         out_ff.valid   <= 1'b0;
      end else begin
         stage_ff.valid <= tok_in.valid;
         out_ff.valid   <= out_in.valid;
      end
      stage_ff.last <= tok_in.last;
      stage_ff.col  <= tok_in.col;
      stage_ff.part <= tok_in.part;
      out_ff.last   <= out_in.last;
      out_ff.col    <= out_in.col;
      out_ff.part   <= out_in.part;
   end

   assign tok_out = out_ff;

endmodule

`default_nettype wire

>>> design/window_height_range_filter_top.sv
// window_height_range_filter_top: raster height stream in, windowed max minus min out
// depends on whrf_pkg and whrf_cell
`default_nettype none

// The grid arrives in raster order, one cell per req item. Each item is written into a line
// store split over a chain of 15 cells, one per window row slot, each owning one 512-entry
// line. An item that completes windows starts a batch of results (up to 64, in raster
// order, batch_last on the final one). Each result sweeps the window's columns into the
// chain, one column a cycle; every cell reads its own line and folds the entry into the
// passing column summary, and the summaries are merged at the chain end. Each sweep passes
// the two register stages of every cell; an item that completes no window leaves the block
// idle for the next item. Results wait in an output register, so the next item is taken
// while the last result of a batch is still pending. A write to any of the three registers
// restarts the frame at cell (0,0); configure only while idle. The store has no reset state.

module window_height_range_filter_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire whrf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output whrf_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [whrf_pkg::ROWS_W-1:0] csr_data
);

   localparam int ROW_W  = whrf_pkg::ROW_W;
   localparam int COL_W  = whrf_pkg::COL_W;
   localparam int SLOT_W = whrf_pkg::SLOT_W;
   localparam int RAD_W  = whrf_pkg::RAD_W;
   localparam int ROWS_W = whrf_pkg::ROWS_W;
   localparam int COLS_W = whrf_pkg::COLS_W;
   localparam int NCELL  = whrf_pkg::WIN_ROWS;

   // configuration
   logic [ROWS_W-1:0] rows_cfg_ff;
   logic [COLS_W-1:0] cols_cfg_ff;
   logic [RAD_W-1:0]  rad_cfg_ff;
   logic [ROWS_W-1:0] rows;
   logic [COLS_W-1:0] cols;
   logic [RAD_W-1:0]  rad;
   logic [ROW_W-1:0]  rows_m1;
   logic [COL_W-1:0]  cols_m1;
   logic [ROW_W-1:0]  rad_r;
   logic [COL_W-1:0]  rad_c;
   logic              csr_write;

   // frame position of the next input item
   logic [ROW_W-1:0]  row_cnt_ff, row_cnt_in;
   logic [COL_W-1:0]  col_cnt_ff, col_cnt_in;
   logic [SLOT_W-1:0] slot_cnt_ff, slot_cnt_in;

   // batch bounds and current result centre
   logic [ROW_W-1:0]  rhi_ff, rhi_in, rr_ff, rr_in;
   logic [COL_W-1:0]  clo_ff, clo_in, chi_ff, chi_in, cc_ff, cc_in;
   logic [SLOT_W-1:0] slot_rr_ff, slot_rr_in;

   // window of the current result
   logic [SLOT_W-1:0] s0_ff, s0_in, nr_ff, nr_in;
   logic [COL_W-1:0]  j1_ff, j1_in, col_ff, col_in;
   whrf_pkg::part_type acc_ff, acc_in;

   whrf_pkg::state_type state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   whrf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // batch figures at item accept
   logic              any_r, any_c;
   logic [ROW_W-1:0]  rlo, rhi;
   logic [COL_W-1:0]  clo, chi;
   logic [SLOT_W-1:0] slot_rlo;

   // window figures for the current centre
   logic [ROW_W-1:0]  i0, i1;
   logic [ROWS_W-1:0] i_up;
   logic [COL_W-1:0]  j0, j1;
   logic [COLS_W-1:0] j_up;

   logic              wr_go;
   whrf_pkg::wr_type  wr;
   logic [NCELL-1:0]  wr_en;
   logic [NCELL-1:0]  use_row;
   whrf_pkg::token_type tok_head;
   whrf_pkg::token_type tok [NCELL+1];
   logic [16:0]       diff;
   logic              res_last;

   // clamp registers to their meaningful ranges
   always_comb begin
      if (rows_cfg_ff == '0) rows = ROWS_W'(1);
      else if (rows_cfg_ff > ROWS_W'(whrf_pkg::MAX_ROWS)) rows = ROWS_W'(whrf_pkg::MAX_ROWS);
      else rows = rows_cfg_ff;
      if (cols_cfg_ff == '0) cols = COLS_W'(1);
      else if (cols_cfg_ff > COLS_W'(whrf_pkg::MAX_COLS)) cols = COLS_W'(whrf_pkg::MAX_COLS);
      else cols = cols_cfg_ff;
      if (rad_cfg_ff == '0) rad = RAD_W'(1);
      else if (rad_cfg_ff > RAD_W'(whrf_pkg::MAX_RADIUS)) rad = RAD_W'(whrf_pkg::MAX_RADIUS);
      else rad = rad_cfg_ff;
   end

   assign rows_m1   = ROW_W'(rows - ROWS_W'(1));
   assign cols_m1   = COL_W'(cols - COLS_W'(1));
   assign rad_r     = ROW_W'(rad);
   assign rad_c     = COL_W'(rad);
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && (csr_index == whrf_pkg::CSR_GRID_ROWS ||
                                    csr_index == whrf_pkg::CSR_GRID_COLS ||
                                    csr_index == whrf_pkg::CSR_WINDOW_RADIUS);

   // which centres the incoming item completes
   always_comb begin
      any_r = 1'b1;
      any_c = 1'b1;
      if (row_cnt_ff == rows_m1) begin
         rhi = rows_m1;
         rlo = (rows_m1 >= rad_r) ? rows_m1 - rad_r : '0;
      end else if (row_cnt_ff >= rad_r) begin
         rhi = row_cnt_ff - rad_r;
         rlo = rhi;
      end else begin
         any_r = 1'b0;
         rhi   = '0;
         rlo   = '0;
      end
      if (col_cnt_ff == cols_m1) begin
         chi = cols_m1;
         clo = (cols_m1 >= rad_c) ? cols_m1 - rad_c : '0;
      end else if (col_cnt_ff >= rad_c) begin
         chi = col_cnt_ff - rad_c;
         clo = chi;
      end else begin
         any_c = 1'b0;
         chi   = '0;
         clo   = '0;
      end
      slot_rlo = whrf_pkg::slot_sub(slot_cnt_ff, SLOT_W'(row_cnt_ff - rlo));
   end

   // truncated window around the current centre
   always_comb begin
      i0   = (rr_ff >= rad_r) ? rr_ff - rad_r : '0;
      i_up = {1'b0, rr_ff} + ROWS_W'(rad);
      i1   = (i_up > {1'b0, rows_m1}) ? rows_m1 : ROW_W'(i_up);
      j0   = (cc_ff >= rad_c) ? cc_ff - rad_c : '0;
      j_up = {1'b0, cc_ff} + COLS_W'(rad);
      j1   = (j_up > {1'b0, cols_m1}) ? cols_m1 : COL_W'(j_up);
   end

   assign res_last = (rr_ff == rhi_ff) && (cc_ff == chi_ff);
   assign diff     = {acc_ff.hi[15], acc_ff.hi} - {acc_ff.lo[15], acc_ff.lo};

   // controller
   always_comb begin
      state_in     = state_ff;
      row_cnt_in   = row_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      slot_cnt_in  = slot_cnt_ff;
      rhi_in       = rhi_ff;
      rr_in        = rr_ff;
      clo_in       = clo_ff;
      chi_in       = chi_ff;
      cc_in        = cc_ff;
      slot_rr_in   = slot_rr_ff;
      s0_in        = s0_ff;
      nr_in        = nr_ff;
      j1_in        = j1_ff;
      col_in       = col_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_go        = 1'b0;
      req_ready    = (state_ff == whrf_pkg::ST_IDLE);
      tok_head.valid = 1'b0;
      tok_head.last  = (col_ff == j1_ff);
      tok_head.col   = col_ff;
      tok_head.part  = whrf_pkg::PART_EMPTY;

      // column summaries leaving the chain
      if (tok[NCELL].valid) acc_in = whrf_pkg::merge_part(acc_ff, tok[NCELL].part);

      case (state_ff)
         whrf_pkg::ST_IDLE: begin
            if (req_valid) begin
               wr_go = 1'b1;
               if (col_cnt_ff == cols_m1) begin
                  col_cnt_in = '0;
                  if (row_cnt_ff == rows_m1) begin
                     row_cnt_in  = '0;
                     slot_cnt_in = '0;
                  end else begin
                     row_cnt_in  = row_cnt_ff + ROW_W'(1);
                     slot_cnt_in = whrf_pkg::slot_inc(slot_cnt_ff);
                  end
               end else begin
                  col_cnt_in = col_cnt_ff + COL_W'(1);
               end
               if (any_r && any_c) begin
                  rhi_in     = rhi;
                  rr_in      = rlo;
                  clo_in     = clo;
                  chi_in     = chi;
                  cc_in      = clo;
                  slot_rr_in = slot_rlo;
                  state_in   = whrf_pkg::ST_SETUP;
               end
            end
         end
         whrf_pkg::ST_SETUP: begin
            s0_in    = whrf_pkg::slot_sub(slot_rr_ff, SLOT_W'(rr_ff - i0));
            nr_in    = SLOT_W'(i1 - i0 + ROW_W'(1));
            col_in   = j0;
            j1_in    = j1;
            acc_in   = whrf_pkg::PART_EMPTY;
            state_in = whrf_pkg::ST_FEED;
         end
         whrf_pkg::ST_FEED: begin
            tok_head.valid = 1'b1;
            col_in         = col_ff + COL_W'(1);
            if (col_ff == j1_ff) state_in = whrf_pkg::ST_DRAIN;
         end
         whrf_pkg::ST_DRAIN: begin
            if (tok[NCELL].valid && tok[NCELL].last) state_in = whrf_pkg::ST_RESULT;
         end
         whrf_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_row  = rr_ff;
               rsp_data_in.out_col  = cc_ff;
               rsp_data_in.batch_last = res_last;
               if (acc_ff.cnt == whrf_pkg::CNT_W'(whrf_pkg::MIN_VALID)) begin
                  rsp_data_in.height_range = diff[15:0];
                  rsp_data_in.range_valid  = 1'b1;
               end else begin
                  rsp_data_in.height_range = '0;
                  rsp_data_in.range_valid  = 1'b0;
               end
               if (res_last) begin
                  state_in = whrf_pkg::ST_IDLE;
               end else begin
                  state_in = whrf_pkg::ST_SETUP;
                  if (cc_ff == chi_ff) begin
                     cc_in      = clo_ff;
                     rr_in      = rr_ff + ROW_W'(1);
                     slot_rr_in = whrf_pkg::slot_inc(slot_rr_ff);
                  end else begin
                     cc_in = cc_ff + COL_W'(1);
                  end
               end
            end
         end
         default: state_in = whrf_pkg::ST_IDLE;
      endcase

      // any register write restarts the frame
      if (csr_write) begin
         row_cnt_in  = '0;
         col_cnt_in  = '0;
         slot_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= whrf_pkg::ST_IDLE;
         rows_cfg_ff  <= ROWS_W'(whrf_pkg::MAX_ROWS);
         cols_cfg_ff  <= COLS_W'(whrf_pkg::MAX_COLS);
         rad_cfg_ff   <= RAD_W'(1);
         row_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         slot_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         slot_cnt_ff  <= slot_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index == whrf_pkg::CSR_GRID_ROWS)
            rows_cfg_ff <= csr_data;
         if (csr_valid && csr_index == whrf_pkg::CSR_GRID_COLS)
            cols_cfg_ff <= csr_data[COLS_W-1:0];
         if (csr_valid && csr_index == whrf_pkg::CSR_WINDOW_RADIUS)
            rad_cfg_ff <= csr_data[RAD_W-1:0];
      end
      rhi_ff      <= rhi_in;
      rr_ff       <= rr_in;
      clo_ff      <= clo_in;
      chi_ff      <= chi_in;
      cc_ff       <= cc_in;
      slot_rr_ff  <= slot_rr_in;
      s0_ff       <= s0_in;
      nr_ff       <= nr_in;
      j1_ff       <= j1_in;
      col_ff      <= col_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // store write for the incoming item, shared by all cells
   assign wr.col          = col_cnt_ff;
   assign wr.entry.valid  = req_data.height_valid;
   assign wr.entry.height = req_data.height;

   // head of the chain
   assign tok[0] = tok_head;

   // cell chain, one cell per row slot of the window
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      logic [SLOT_W-1:0] slot_dist;
      assign wr_en[k]   = wr_go && (slot_cnt_ff == SLOT_W'(k));
      assign slot_dist  = whrf_pkg::slot_sub(SLOT_W'(k), s0_ff);
      assign use_row[k] = (slot_dist < nr_ff);

      whrf_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (wr_en[k]),
         .wr      (wr),
         .use_row (use_row[k]),
         .tok_in  (tok[k]),
         .tok_out (tok[k+1])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // column summaries only come out while a window is being swept
   a_chain_busy: assert property (@(posedge clock) disable iff (reset)
      tok[NCELL].valid |-> (state_ff == whrf_pkg::ST_FEED || state_ff == whrf_pkg::ST_DRAIN))
      else $error("column summary outside a window sweep");

   // no item lands in more than one line
   a_one_line: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_en))
      else $error("item written into more than one line");

   // a counted window has its minimum not above its maximum
   a_acc_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == whrf_pkg::ST_RESULT &&
       acc_ff.cnt == whrf_pkg::CNT_W'(whrf_pkg::MIN_VALID)) |-> (acc_ff.lo <= acc_ff.hi))
      else $error("window minimum above maximum");

endmodule

`default_nettype wire

>>> sim/window_height_range_filter_checker.sv
// window_height_range_filter_checker: watches the req, rsp and csr channels, predicts windowed ranges
// depends on whrf_pkg; instantiated beside the block by tb_window_height_range_filter_top
`default_nettype none

module window_height_range_filter_checker
   import whrf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire req_type             req_data,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire rsp_type             rsp_data,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [ROWS_W-1:0]   csr_data,
   output int                       fail_count,
   output int                       pending_count
);

   logic [16:0]  height_mem [WIN_ROWS][MAX_COLS];
   logic [10:0]  rows_reg;
   logic [9:0]   cols_reg;
   logic [2:0]   radius_reg;
   int           row_pos;
   int           col_pos;
   rsp_type      range_q [$];

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // max minus min of the valid heights in the truncated window around (rr, cc)
   function automatic rsp_type window_range(int rr, int cc, int rad, int rows, int cols);
      rsp_type r;
      int lo, hi, n, h;
      lo = 32767;
      hi = -32768;
      n = 0;
      for (int i = (rr >= rad ? rr - rad : 0); i <= (rr + rad < rows - 1 ? rr + rad : rows - 1);
           i++) begin
         for (int j = (cc >= rad ? cc - rad : 0);
              j <= (cc + rad < cols - 1 ? cc + rad : cols - 1); j++) begin
            if (height_mem[i % WIN_ROWS][j][16]) begin
               h = int'($signed(height_mem[i % WIN_ROWS][j][15:0]));
               if (h < lo) lo = h;
               if (h > hi) hi = h;
               n++;
            end
         end
      end
      r.out_row      = ROW_W'(rr);
      r.out_col      = COL_W'(cc);
      r.range_valid  = (n >= MIN_VALID);
      r.height_range = (n >= MIN_VALID) ? 16'(hi - lo) : 16'd0;
      r.batch_last   = 1'b0;
      return r;
   endfunction

   task automatic predict_cell(req_type d);
      int rows, cols, rad, i, j, rlo, rhi, clo, chi;
      bit any_r, any_c;
      rsp_type r;
      rows = clamp_int(int'(rows_reg), 1, MAX_ROWS);
      cols = clamp_int(int'(cols_reg), 1, MAX_COLS);
      rad  = clamp_int(int'(radius_reg), 1, MAX_RADIUS);
      i = (row_pos >= rows) ? 0 : row_pos;
      j = (col_pos >= cols) ? 0 : col_pos;
      height_mem[i % WIN_ROWS][j] = {d.height_valid, d.height};
      any_r = 1;
      any_c = 1;
      rlo = 0; rhi = 0; clo = 0; chi = 0;
      if (i == rows - 1) begin
         rlo = (rows - 1 >= rad) ? rows - 1 - rad : 0;
         rhi = rows - 1;
      end else if (i >= rad) begin
         rlo = i - rad;
         rhi = rlo;
      end else begin
         any_r = 0;
      end
      if (j == cols - 1) begin
         clo = (cols - 1 >= rad) ? cols - 1 - rad : 0;
         chi = cols - 1;
      end else if (j >= rad) begin
         clo = j - rad;
         chi = clo;
      end else begin
         any_c = 0;
      end
      if (any_r && any_c) begin
         for (int rr = rlo; rr <= rhi; rr++) begin
            for (int cc = clo; cc <= chi; cc++) begin
               r = window_range(rr, cc, rad, rows, cols);
               r.batch_last = (rr == rhi && cc == chi);
               range_q = {range_q, r};
            end
         end
      end
      j++;
      if (j >= cols) begin
         j = 0;
         i++;
         if (i >= rows) i = 0;
      end
      row_pos = i;
      col_pos = j;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic compare_range(rsp_type got);
      rsp_type want;
      if (range_q.size() == 0) begin
         report_mismatch("unexpected rsp item, row", int'(got.out_row), -1);
         return;
      end
      want = range_q.pop_front();
      if (got.out_row != want.out_row)
         report_mismatch("out_row", int'(got.out_row), int'(want.out_row));
      if (got.out_col != want.out_col)
         report_mismatch("out_col", int'(got.out_col), int'(want.out_col));
      if (got.height_range != want.height_range)
         report_mismatch("height_range", int'(got.height_range), int'(want.height_range));
      if (got.range_valid != want.range_valid)
         report_mismatch("range_valid", int'(got.range_valid), int'(want.range_valid));
      if (got.batch_last != want.batch_last)
         report_mismatch("batch_last", int'(got.batch_last), int'(want.batch_last));
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      for (int s = 0; s < WIN_ROWS; s++)
         for (int c = 0; c < MAX_COLS; c++)
            height_mem[s][c] = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rows_reg   <= 11'd1024;
         cols_reg   <= 10'd512;
         radius_reg <= 3'd1;
         row_pos    <= 0;
         col_pos    <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            compare_range(rsp_data);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_ROWS: begin
                  rows_reg = csr_data[10:0];
                  row_pos = 0;
                  col_pos = 0;
               end
               CSR_GRID_COLS: begin
                  cols_reg = csr_data[9:0];
                  row_pos = 0;
                  col_pos = 0;
               end
               CSR_WINDOW_RADIUS: begin
                  radius_reg = csr_data[2:0];
                  row_pos = 0;
                  col_pos = 0;
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_cell(req_data);
      end
      pending_count = range_q.size();
   end

endmodule

`default_nettype wire

>>> sim/tb_window_height_range_filter_top.sv
// tb_window_height_range_filter_top: stimulus, clock, reset and verdict for the range filter
// depends on whrf_pkg, window_height_range_filter_top and window_height_range_filter_checker
`default_nettype none

module tb_window_height_range_filter_top;
   import whrf_pkg::*;

   localparam int STALL_LIMIT = 20000;   // cycles with no item moving on any channel
   localparam int LONG_HOLD   = 400;     // receiver hold-off, enough to back up the block
   localparam int SETTLE      = 150;     // covers the tail of a result batch and quiet items
   localparam int ITEM_COUNT  = 130;     // input items over the whole run

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = CSR_GRID_ROWS;
   logic [ROWS_W-1:0]   csr_data = '0;

   int fail_count;
   int pending_count;
   int cells_sent = 0;
   int burst_left = 4;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int ready_mode = 0;
   int mode_left = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   window_height_range_filter_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   window_height_range_filter_checker range_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // receiver: long hold-offs on request, otherwise one of three random ready patterns, each held for a random run
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(8, 60);
         end
         mode_left = mode_left - 1;
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog: ends the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one cell per item; the sender runs in bursts with random gaps in between
   task automatic send_cell(logic signed [15:0] h, logic v);
      req_valid <= 1'b1;
      req_data <= '{height: h, height_valid: v};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cells_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      end
   endtask

   // drop valid and wait for every expected result plus the block's tail
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [ROWS_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(int rows, int cols, int rad);
      write_csr(CSR_GRID_ROWS, ROWS_W'(rows));
      write_csr(CSR_GRID_COLS, ROWS_W'(cols));
      write_csr(CSR_WINDOW_RADIUS, ROWS_W'(rad));
   endtask

   // wide random, the two extremes, or a small spread around zero
   function automatic logic signed [15:0] pick_height();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return -16'sh8000;
         2: return 16'($urandom_range(0, 200)) - 16'sd100;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic pick_valid();
      return ($urandom_range(0, 7) != 0);
   endfunction

   initial begin
      int rows, cols, rad, n_cells, phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (5) @(posedge clock);

      // zero sizes and zero radius act as one: a single-cell grid, never a valid range
      set_grid(0, 0, 0);
      send_cell(16'sd5, 1'b1);
      send_cell(-16'sd7, 1'b0);
      settle_idle();

      // extremes in one small grid: full 16-bit range, and cells without a valid height
      set_grid(2, 3, 1);
      send_cell(16'sh7fff, 1'b1);
      send_cell(-16'sh8000, 1'b1);
      send_cell(16'sd0, 1'b0);
      send_cell(16'sd1, 1'b0);
      send_cell(-16'sd1, 1'b0);
      send_cell(16'sh5555, 1'b1);
      settle_idle();

      // oversize sizes clamp to the maximum grid; few cells so no window completes
      set_grid(2047, 1023, 7);
      send_cell(16'sd3, 1'b1);
      send_cell(16'shaaaa, 1'b1);
      send_cell(16'sd9, 1'b0);
      settle_idle();

      // a write beyond the register list must not restart the frame
      set_grid(3, 4, 2);
      for (int k = 0; k < 5; k++) send_cell(pick_height(), pick_valid());
      settle_idle();
      write_csr(2'd3, '1);
      for (int k = 0; k < 7; k++) send_cell(pick_height(), pick_valid());
      settle_idle();

      // the first grid gives the largest batch of results, the second has results after
      // nearly every item so a long receiver hold backs the block up; then random grids
      phase = 0;
      while (cells_sent < ITEM_COUNT) begin
         if (phase == 0) begin
            rows = 8; cols = 8; rad = 7;
         end else if (phase == 1) begin
            rows = 6; cols = 6; rad = 1;
         end else begin
            rows = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
            cols = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
            rad  = $urandom_range(0, 7);
         end
         // upper csr bits set at random where the register ignores them
         set_grid(rows, cols, rad | ($urandom_range(0, 255) << 3));
         n_cells = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols);
         if (phase > 1 && $urandom_range(0, 4) == 0) n_cells = $urandom_range(1, n_cells);
         if (n_cells > ITEM_COUNT - cells_sent) n_cells = ITEM_COUNT - cells_sent;
         for (int k = 0; k < n_cells; k++) begin
            if (phase == 1 && k == 8) hold_asks++;          // back the block up
            if (phase == 1 && k == 3) settle_idle();        // sender waits for every result
            send_cell(pick_height(), pick_valid());
         end
         settle_idle();
         phase++;
      end

      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
design/whrf_pkg.sv
design/whrf_cell.sv
design/window_height_range_filter_top.sv
sim/window_height_range_filter_checker.sv
sim/tb_window_height_range_filter_top.sv
